// ===== hw/rtl/rhsv_pkg.sv =====
// ----------------------------------------------------------------------------
// RGB to HSV converter package
// Widths, word types and the lane record carried down the divider chain.
// ----------------------------------------------------------------------------
package rhsv_pkg;

   localparam int COLOR_BITS = 8;
   localparam int HUE_BITS   = 16;

   // 6*delta and the normalized raw hue both fit here
   localparam int REM_BITS     = COLOR_BITS + 3;
   localparam int SAT_NUM_BITS = 2 * COLOR_BITS;
   localparam int NUM_CELLS    = (HUE_BITS > SAT_NUM_BITS) ? HUE_BITS : SAT_NUM_BITS;
   localparam int LATENCY      = NUM_CELLS + 2;

   typedef struct packed {
      logic [COLOR_BITS-1:0] red;
      logic [COLOR_BITS-1:0] green;
      logic [COLOR_BITS-1:0] blue;
   } rhsv_req_type;

   typedef struct packed {
      logic [HUE_BITS-1:0]   hue;
      logic [COLOR_BITS-1:0] saturation;
      logic [COLOR_BITS-1:0] brightness;
      logic                  hue_defined;
   } rhsv_rsp_type;

   typedef struct packed {
      logic hue;
      logic sat;
   } rhsv_step_en_type;

   typedef struct packed {
      logic                    valid;
      logic [COLOR_BITS-1:0]   brightness;
      logic [REM_BITS-1:0]     hue_rem;
      logic [REM_BITS-1:0]     hue_den;
      logic [HUE_BITS-1:0]     hue_quo;
      logic [SAT_NUM_BITS-1:0] sat_num;
      logic [COLOR_BITS-1:0]   sat_rem;
      logic [COLOR_BITS-1:0]   sat_quo;
   } rhsv_lane_type;

endpackage

// ===== hw/rtl/rhsv_front.sv =====
// ----------------------------------------------------------------------------
// RGB to HSV front stage
// Max, min, delta, raw hue and divider operands for one pixel, registered.
// ----------------------------------------------------------------------------
module rhsv_front
   import rhsv_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          fire,
   input  rhsv_req_type  req_word,
   output rhsv_lane_type lane_o
);

   localparam int RAW_BITS = COLOR_BITS + 4;

   rhsv_lane_type lane_ff;
   rhsv_lane_type lane_in;

   logic [COLOR_BITS-1:0]      mx;
   logic [COLOR_BITS-1:0]      mn;
   logic [COLOR_BITS-1:0]      delta;
   logic signed [RAW_BITS-1:0] rs;
   logic signed [RAW_BITS-1:0] gs;
   logic signed [RAW_BITS-1:0] bs;
   logic signed [RAW_BITS-1:0] ds;
   logic signed [RAW_BITS-1:0] raw;
   logic signed [RAW_BITS-1:0] raw_norm;
   logic [REM_BITS-1:0]        d6;

   always_comb begin
      mx = req_word.red;
      mn = req_word.red;
      if (req_word.green > mx) mx = req_word.green;
      if (req_word.blue > mx)  mx = req_word.blue;
      if (req_word.green < mn) mn = req_word.green;
      if (req_word.blue < mn)  mn = req_word.blue;
      delta = mx - mn;

      rs = $signed({4'b0000, req_word.red});
      gs = $signed({4'b0000, req_word.green});
      bs = $signed({4'b0000, req_word.blue});
      ds = $signed({4'b0000, delta});

      if (req_word.red == mx) begin
         raw = gs - bs;
      end else if (req_word.green == mx) begin
         raw = (ds <<< 1) + bs - rs;
      end else begin
         raw = (ds <<< 2) + rs - gs;
      end
      raw_norm = raw[RAW_BITS-1] ? raw + (ds <<< 2) + (ds <<< 1) : raw;

      d6 = ({3'b000, delta} << 2) + ({3'b000, delta} << 1);

      lane_in            = lane_ff;
      lane_in.valid      = fire;
      lane_in.brightness = mx;
      lane_in.hue_rem    = raw_norm[REM_BITS-1:0];
      lane_in.hue_den    = d6;
      lane_in.hue_quo    = '0;
      lane_in.sat_num    = {delta, {COLOR_BITS{1'b0}}} - {{COLOR_BITS{1'b0}}, delta};
      lane_in.sat_rem    = '0;
      lane_in.sat_quo    = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lane_ff <= '0;
      end else begin
         lane_ff <= lane_in;
      end
   end

   assign lane_o = lane_ff;

endmodule

// ===== hw/rtl/rhsv_div_cell.sv =====
// ----------------------------------------------------------------------------
// RGB to HSV divider cell
// One restoring step each for the hue and saturation quotients.
// ----------------------------------------------------------------------------
module rhsv_div_cell
   import rhsv_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  rhsv_step_en_type step_en,
   input  rhsv_lane_type    lane_i,
   output rhsv_lane_type    lane_o
);

   rhsv_lane_type lane_ff;
   rhsv_lane_type lane_in;

   logic [REM_BITS:0]   hue_trial;
   logic                hue_fit;
   logic [COLOR_BITS:0] sat_trial;
   logic                sat_fit;

   always_comb begin
      hue_trial = {lane_i.hue_rem, 1'b0};
      hue_fit   = hue_trial >= {1'b0, lane_i.hue_den};
      sat_trial = {lane_i.sat_rem, lane_i.sat_num[SAT_NUM_BITS-1]};
      sat_fit   = sat_trial >= {1'b0, lane_i.brightness};

      lane_in = lane_i;
      if (step_en.hue) begin
         lane_in.hue_rem = hue_fit ? REM_BITS'(hue_trial - {1'b0, lane_i.hue_den})
                                   : hue_trial[REM_BITS-1:0];
         lane_in.hue_quo = {lane_i.hue_quo[HUE_BITS-2:0], hue_fit};
      end
      if (step_en.sat) begin
         lane_in.sat_rem = sat_fit ? COLOR_BITS'(sat_trial - {1'b0, lane_i.brightness})
                                   : sat_trial[COLOR_BITS-1:0];
         lane_in.sat_quo = {lane_i.sat_quo[COLOR_BITS-2:0], sat_fit};
         lane_in.sat_num = {lane_i.sat_num[SAT_NUM_BITS-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lane_ff <= '0;
      end else begin
         lane_ff <= lane_in;
      end
   end

   assign lane_o = lane_ff;

endmodule

// ===== hw/rtl/rgb_to_hsv_converter_unit.sv =====
// ----------------------------------------------------------------------------
// RGB to HSV converter
// Converts one RGB pixel word per clock into hue, saturation and brightness.
// ----------------------------------------------------------------------------
// A pixel word on req_word is taken at a rising edge where start is high and
// busy is low; busy is always low, so a new pixel may enter every clock.
// Each pixel gives exactly one result word on rsp_word, marked by rsp_valid
// for one cycle, in input order. The receiver cannot stall the block.
// From the accepting edge to the edge that takes the result, a pixel goes
// through one front stage (max, min, raw hue), a chain of 16 divider cells,
// one quotient bit per cell for both the hue and the saturation quotient,
// and an output register. Throughput is one pixel per clock. Reset clears
// the valid bits of every stage; words in flight are dropped and no result
// appears until a new pixel is accepted.
// ----------------------------------------------------------------------------
module rgb_to_hsv_converter_unit
   import rhsv_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  rhsv_req_type req_word,
   output logic         rsp_valid,
   output rhsv_rsp_type rsp_word
);

   rhsv_lane_type lane [0:NUM_CELLS];

   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   rhsv_rsp_type          rsp_word_ff;
   rhsv_rsp_type          rsp_word_in;
   logic [COLOR_BITS-1:0] sat_val;

   assign busy = 1'b0;

   rhsv_front u_front (
      .clock    (clock),
      .reset    (reset),
      .fire     (start && !busy),
      .req_word (req_word),
      .lane_o   (lane[0])
   );

   for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
      localparam rhsv_step_en_type STEP_EN = '{hue: (i < HUE_BITS), sat: (i < SAT_NUM_BITS)};
      rhsv_div_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .step_en (STEP_EN),
         .lane_i  (lane[i]),
         .lane_o  (lane[i+1])
      );
   end

   always_comb begin
      sat_val                 = (lane[NUM_CELLS].brightness == '0) ? '0
                                                                   : lane[NUM_CELLS].sat_quo;
      rsp_valid_in            = lane[NUM_CELLS].valid;
      rsp_word_in.saturation  = sat_val;
      rsp_word_in.brightness  = lane[NUM_CELLS].brightness;
      rsp_word_in.hue_defined = (sat_val != '0);
      rsp_word_in.hue         = (sat_val != '0) ? lane[NUM_CELLS].hue_quo : '0;
   end

   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   a_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start, LATENCY))
      else $error("result without a pixel accepted at the pipeline latency");

   a_black: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_word.brightness == '0) |->
         (rsp_word.saturation == '0 && !rsp_word.hue_defined))
      else $error("black pixel with nonzero saturation or defined hue");

   a_undef_hue: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_word.hue_defined) |-> (rsp_word.hue == '0))
      else $error("undefined hue not zero");

   a_flow: assert property (@(posedge clock) disable iff (reset)
      lane[NUM_CELLS].valid |=> rsp_valid)
      else $error("last cell word lost at output register");

endmodule
